>>> design/pale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pale_pkg
// Shared widths and types for the polygon area, length and extent block.
// ----------------------------------------------------------------------------
package pale_pkg;
  localparam int COORD_BITS = 24;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS;       // dx^2 + dy^2, even width
  localparam int ROOT_BITS  = (SQ_BITS + 1) / 2;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int NCELL      = ROOT_BITS;
  localparam int AREA_BITS  = 64;
  localparam int LEN_BITS   = 48;
  localparam int EXT_BITS   = 24;

  // Data handed from one root cell to the next.
  typedef struct packed {
    logic                 vld;
    logic [SQ_BITS-1:0]   rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    logic                 last;
  } sqrt_word_t;
endpackage
`default_nettype wire

>>> design/pale_root_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pale_root_cell
// One step of a restoring square root: takes two radicand bits and decides
// one root bit, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module pale_root_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire pale_pkg::sqrt_word_t din,
  output pale_pkg::sqrt_word_t     dout
);
  import pale_pkg::*;

  logic [REM_BITS-1:0] rem_sh;
  logic [REM_BITS-1:0] trial;
  logic                take;
  sqrt_word_t          dnext;

  always_comb begin
    rem_sh = {din.rem[REM_BITS-3:0], din.rad[SQ_BITS-1:SQ_BITS-2]};
    trial  = {din.root, 2'b01};
    take   = rem_sh >= trial;
    dnext  = din;
    dnext.rad  = {din.rad[SQ_BITS-3:0], 2'b00};
    dnext.rem  = take ? rem_sh - trial : rem_sh;
    dnext.root = {din.root[ROOT_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.rad  <= dnext.rad;
      dout.rem  <= dnext.rem;
      dout.root <= dnext.root;
      dout.last <= dnext.last;
    end
  end
endmodule
`default_nettype wire

>>> design/polygon_area_length_extent.sv
// Path: an input word is loaded into the front stage at the accepting edge,
// then passes one root cell per result bit, then the output register.
// Throughput: one point per cycle; the cell chain advances whenever the
// output register is free or being emptied.
// Reset: synchronous rst clears all sums, extents and valid flags.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_area_length_extent
// Shoelace area, path length and bounding extent over a stream of points.
// ----------------------------------------------------------------------------
module polygon_area_length_extent (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [pale_pkg::COORD_BITS-1:0] x_coord,
  input  wire logic signed [pale_pkg::COORD_BITS-1:0] y_coord,
  input  wire logic                                   part_start,
  input  wire logic                                   geom_end,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [62:0]                          area,
  output logic [pale_pkg::LEN_BITS-1:0]               path_length,
  output logic [pale_pkg::EXT_BITS-1:0]               extent_width,
  output logic [pale_pkg::EXT_BITS-1:0]               extent_height
);
  import pale_pkg::*;

  logic en;
  logic acc;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  // Per-point state, updated directly on acceptance.
  logic signed [COORD_BITS-1:0] first_x, prev_x, prev_y, pprev_y;
  logic [1:0]                   npts;
  logic                         open_part;
  logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
  logic                         have_point;

  logic [1:0] npts_eff;
  logic signed [DIFF_BITS-1:0] dx, dy, ta, tb;
  logic signed [2*DIFF_BITS-1:0] sq_x, sq_y;
  always_comb begin
    npts_eff = (part_start || !open_part) ? 2'd0 : npts;
    dx = DIFF_BITS'(x_coord) - DIFF_BITS'(prev_x);
    dy = DIFF_BITS'(y_coord) - DIFF_BITS'(prev_y);
    ta = DIFF_BITS'(prev_x) - DIFF_BITS'(first_x);
    tb = DIFF_BITS'(pprev_y) - DIFF_BITS'(y_coord);
    sq_x = dx * dx;
    sq_y = dy * dy;
  end

  // Stage 1: squares, area product, extents and flags.
  logic                        s1_vld, s1_seg, s1_area, s1_last;
  logic [2*DIFF_BITS-1:0]      s1_sx, s1_sy;
  logic signed [2*DIFF_BITS-1:0] s1_prod;
  logic [EXT_BITS-1:0]         s1_w, s1_h;

  logic signed [COORD_BITS-1:0] nmin_x, nmax_x, nmin_y, nmax_y;
  always_comb begin
    if (!have_point) begin
      nmin_x = x_coord; nmax_x = x_coord; nmin_y = y_coord; nmax_y = y_coord;
    end else begin
      nmin_x = (x_coord < min_x) ? x_coord : min_x;
      nmax_x = (x_coord > max_x) ? x_coord : max_x;
      nmin_y = (y_coord < min_y) ? y_coord : min_y;
      nmax_y = (y_coord > max_y) ? y_coord : max_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0; open_part <= 1'b0; have_point <= 1'b0; npts <= 2'd0;
      first_x <= '0; prev_x <= '0; prev_y <= '0; pprev_y <= '0;
      min_x <= '0; max_x <= '0; min_y <= '0; max_y <= '0;
    end else if (en) begin
      s1_vld <= acc;
      if (acc) begin
        if (geom_end) begin
          open_part <= 1'b0; have_point <= 1'b0;
          first_x <= '0; prev_x <= '0; prev_y <= '0; pprev_y <= '0;
          npts <= 2'd0;
          min_x <= '0; max_x <= '0; min_y <= '0; max_y <= '0;
        end else begin
          if (npts_eff == 2'd0) first_x <= x_coord;
          pprev_y <= prev_y;
          prev_x  <= x_coord;
          prev_y  <= y_coord;
          npts    <= (npts_eff == 2'd2) ? 2'd2 : npts_eff + 2'd1;
          open_part <= 1'b1; have_point <= 1'b1;
          min_x <= nmin_x; max_x <= nmax_x; min_y <= nmin_y; max_y <= nmax_y;
        end
      end
    end
    if (en) begin
      s1_seg  <= npts_eff != 2'd0;
      s1_area <= npts_eff == 2'd2;
      s1_last <= geom_end;
      s1_sx   <= $unsigned(sq_x);
      s1_sy   <= $unsigned(sq_y);
      s1_prod <= ta * tb;
      s1_w    <= EXT_BITS'(DIFF_BITS'(nmax_x) - DIFF_BITS'(nmin_x));
      s1_h    <= EXT_BITS'(DIFF_BITS'(nmax_y) - DIFF_BITS'(nmin_y));
    end
  end

  // Area and extent do not need the root; they travel in a delay line
  // beside the cells, and the area sum is kept right here.
  logic signed [AREA_BITS-1:0] area_sum;
  logic signed [AREA_BITS:0]   area_wide;
  logic signed [AREA_BITS-1:0] area_next;
  always_comb begin
    area_wide = (AREA_BITS+1)'(area_sum)
              + (s1_area ? (AREA_BITS+1)'(s1_prod) : '0);
    if (area_wide[AREA_BITS] != area_wide[AREA_BITS-1])
      area_next = area_wide[AREA_BITS] ? {1'b1, {(AREA_BITS-1){1'b0}}}
                                       : {1'b0, {(AREA_BITS-1){1'b1}}};
    else
      area_next = area_wide[AREA_BITS-1:0];
  end

  logic signed [AREA_BITS-1:0] area_hold [NCELL];
  logic [EXT_BITS-1:0]         w_hold [NCELL];
  logic [EXT_BITS-1:0]         h_hold [NCELL];

  always_ff @(posedge clk) begin
    if (rst) begin
      area_sum <= '0;
    end else if (en && s1_vld) begin
      area_sum <= s1_last ? '0 : area_next;
    end
    if (en) begin
      area_hold[0] <= area_next;
      w_hold[0]    <= s1_w;
      h_hold[0]    <= s1_h;
      for (int i = 1; i < NCELL; i++) begin
        area_hold[i] <= area_hold[i-1];
        w_hold[i]    <= w_hold[i-1];
        h_hold[i]    <= h_hold[i-1];
      end
    end
  end

  // Chain of root cells.
  sqrt_word_t cw [NCELL+1];
  always_comb begin
    cw[0].vld  = s1_vld;
    cw[0].rad  = s1_seg ? SQ_BITS'(s1_sx) + SQ_BITS'(s1_sy) : '0;
    cw[0].rem  = '0;
    cw[0].root = '0;
    cw[0].last = s1_last;
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    pale_root_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (cw[g]),
      .dout (cw[g+1])
    );
  end

  // Length accumulation and output register.
  logic [LEN_BITS-1:0] len_sum;
  logic [LEN_BITS:0]   len_wide;
  logic [LEN_BITS-1:0] len_next;
  always_comb begin
    len_wide = (LEN_BITS+1)'(len_sum) + (LEN_BITS+1)'(cw[NCELL].root);
    len_next = len_wide[LEN_BITS] ? '1 : len_wide[LEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_sum   <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cw[NCELL].vld && cw[NCELL].last;
      if (cw[NCELL].vld) len_sum <= cw[NCELL].last ? '0 : len_next;
    end
    if (en) begin
      area          <= area_hold[NCELL-1][AREA_BITS-1:1];
      path_length   <= len_next;
      extent_width  <= w_hold[NCELL-1];
      extent_height <= h_hold[NCELL-1];
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(path_length))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_npts: assert property (@(posedge clk) disable iff (rst)
    npts != 2'd3)
    else $error("point count out of range");
`endif
endmodule
`default_nettype wire
